// ===== rtl/core/kst_pkg.sv =====
// Shared types, key codes and character tables for the scan-code translator.
`timescale 1ns / 1ps

package kst_pkg;

  // Field widths
  localparam int unsigned TYPE_W = 5;
  localparam int unsigned CODE_W = 10;
  localparam int unsigned VAL_W  = 2;
  localparam int unsigned MOD_W  = 9;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // Event kind that carries a key
  localparam logic [TYPE_W-1:0] KEY_EVENT = 5'd1;

  // Modifier and special key codes
  localparam logic [CODE_W-1:0] KEY_SHIFTL = 10'h02a;
  localparam logic [CODE_W-1:0] KEY_SHIFTR = 10'h036;
  localparam logic [CODE_W-1:0] KEY_CTRLL  = 10'h01d;
  localparam logic [CODE_W-1:0] KEY_CTRLR  = 10'h061;
  localparam logic [CODE_W-1:0] KEY_ALTL   = 10'h038;
  localparam logic [CODE_W-1:0] KEY_ALTR   = 10'h064;
  localparam logic [CODE_W-1:0] KEY_WINL   = 10'h07d;
  localparam logic [CODE_W-1:0] KEY_WINR   = 10'h07e;
  localparam logic [CODE_W-1:0] KEY_OPTION = 10'h07f;
  localparam logic [CODE_W-1:0] KEY_CAPS   = 10'h03a;
  localparam logic [CODE_W-1:0] KEY_A      = 10'h01e;
  localparam logic [CODE_W-1:0] KEY_O      = 10'h018;
  localparam logic [CODE_W-1:0] KEY_U      = 10'h016;
  localparam logic [CODE_W-1:0] KEY_S      = 10'h01f;
  localparam logic [CODE_W-1:0] KEY_DEL    = 10'h06f;
  localparam logic [CODE_W-1:0] KEY_HOME   = 10'h066;
  localparam logic [CODE_W-1:0] KEY_END    = 10'h06b;
  localparam logic [CODE_W-1:0] KEY_LEFT   = 10'h069;
  localparam logic [CODE_W-1:0] KEY_RIGHT  = 10'h06a;
  localparam logic [CODE_W-1:0] KEY_F1     = 10'h03b;
  localparam logic [CODE_W-1:0] KEY_F2     = 10'h03c;
  localparam logic [CODE_W-1:0] KEY_F3     = 10'h03d;
  localparam logic [CODE_W-1:0] KEY_F4     = 10'h03e;
  localparam logic [CODE_W-1:0] KEY_KPDIV  = 10'h062;
  localparam logic [CODE_W-1:0] PAD_FIRST  = 10'h047;
  localparam logic [CODE_W-1:0] PAD_LAST   = 10'h053;
  localparam logic [CODE_W-1:0] MAIN_FIRST = 10'h001;
  localparam logic [CODE_W-1:0] MAIN_LAST  = 10'h039;

  // Modifier flag bit positions
  localparam int unsigned MB_SHIFTL = 0;
  localparam int unsigned MB_SHIFTR = 1;
  localparam int unsigned MB_CTRLL  = 2;
  localparam int unsigned MB_CTRLR  = 3;
  localparam int unsigned MB_ALTL   = 4;
  localparam int unsigned MB_ALTR   = 5;
  localparam int unsigned MB_WINL   = 6;
  localparam int unsigned MB_WINR   = 7;
  localparam int unsigned MB_OPTION = 8;

  typedef logic [MOD_W-1:0] mod_t;

  // Translator outcome for one beat
  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] char_code;
    logic              is_cooked;
    mod_t              modifier_bits;
    mod_t              mod_nxt;
    logic              caps_nxt;
  } xlate_res_t;

  // One-hot modifier mask for a code, zero for ordinary keys
  function automatic mod_t mod_mask(input logic [CODE_W-1:0] code);
    mod_t m;
    m = '0;
    unique case (code)
      KEY_SHIFTL: m[MB_SHIFTL] = 1'b1;
      KEY_SHIFTR: m[MB_SHIFTR] = 1'b1;
      KEY_CTRLL:  m[MB_CTRLL]  = 1'b1;
      KEY_CTRLR:  m[MB_CTRLR]  = 1'b1;
      KEY_ALTL:   m[MB_ALTL]   = 1'b1;
      KEY_ALTR:   m[MB_ALTR]   = 1'b1;
      KEY_WINL:   m[MB_WINL]   = 1'b1;
      KEY_WINR:   m[MB_WINR]   = 1'b1;
      KEY_OPTION: m[MB_OPTION] = 1'b1;
      default:    m = '0;
    endcase
    return m;
  endfunction

  // Main block, unshifted
  function automatic logic [7:0] base_char(input logic [5:0] code);
    logic [7:0] c;
    unique case (code)
      6'h01: c = 8'h1b; 6'h02: c = 8'h31; 6'h03: c = 8'h32; 6'h04: c = 8'h33;
      6'h05: c = 8'h34; 6'h06: c = 8'h35; 6'h07: c = 8'h36; 6'h08: c = 8'h37;
      6'h09: c = 8'h38; 6'h0a: c = 8'h39; 6'h0b: c = 8'h30; 6'h0c: c = 8'h2d;
      6'h0d: c = 8'h3d; 6'h0e: c = 8'h08; 6'h0f: c = 8'h20; 6'h10: c = 8'h71;
      6'h11: c = 8'h77; 6'h12: c = 8'h65; 6'h13: c = 8'h72; 6'h14: c = 8'h74;
      6'h15: c = 8'h7a; 6'h16: c = 8'h75; 6'h17: c = 8'h69; 6'h18: c = 8'h6f;
      6'h19: c = 8'h70; 6'h1a: c = 8'h5b; 6'h1b: c = 8'h5d; 6'h1c: c = 8'h0d;
      6'h1e: c = 8'h61; 6'h1f: c = 8'h73; 6'h20: c = 8'h64; 6'h21: c = 8'h66;
      6'h22: c = 8'h67; 6'h23: c = 8'h68; 6'h24: c = 8'h6a; 6'h25: c = 8'h6b;
      6'h26: c = 8'h6c; 6'h27: c = 8'h3b; 6'h28: c = 8'h27; 6'h29: c = 8'h60;
      6'h2b: c = 8'h5c; 6'h2c: c = 8'h79; 6'h2d: c = 8'h78; 6'h2e: c = 8'h63;
      6'h2f: c = 8'h76; 6'h30: c = 8'h62; 6'h31: c = 8'h6e; 6'h32: c = 8'h6d;
      6'h33: c = 8'h2c; 6'h34: c = 8'h2e; 6'h35: c = 8'h2f; 6'h37: c = 8'h2a;
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Main block, shifted or caps
  function automatic logic [7:0] shift_char(input logic [5:0] code);
    logic [7:0] c;
    unique case (code)
      6'h01: c = 8'h1b; 6'h02: c = 8'h21; 6'h03: c = 8'h40; 6'h04: c = 8'h23;
      6'h05: c = 8'h24; 6'h06: c = 8'h25; 6'h07: c = 8'h5e; 6'h08: c = 8'h26;
      6'h09: c = 8'h2a; 6'h0a: c = 8'h28; 6'h0b: c = 8'h29; 6'h0c: c = 8'h5f;
      6'h0d: c = 8'h2b; 6'h0e: c = 8'h08; 6'h0f: c = 8'h20; 6'h10: c = 8'h51;
      6'h11: c = 8'h57; 6'h12: c = 8'h45; 6'h13: c = 8'h52; 6'h14: c = 8'h54;
      6'h15: c = 8'h5a; 6'h16: c = 8'h55; 6'h17: c = 8'h49; 6'h18: c = 8'h4f;
      6'h19: c = 8'h50; 6'h1a: c = 8'h7b; 6'h1b: c = 8'h7d; 6'h1c: c = 8'h0d;
      6'h1e: c = 8'h41; 6'h1f: c = 8'h53; 6'h20: c = 8'h44; 6'h21: c = 8'h46;
      6'h22: c = 8'h47; 6'h23: c = 8'h48; 6'h24: c = 8'h4a; 6'h25: c = 8'h4b;
      6'h26: c = 8'h4c; 6'h27: c = 8'h3a; 6'h28: c = 8'h22; 6'h29: c = 8'h7e;
      6'h2b: c = 8'h7c; 6'h2c: c = 8'h59; 6'h2d: c = 8'h58; 6'h2e: c = 8'h43;
      6'h2f: c = 8'h56; 6'h30: c = 8'h42; 6'h31: c = 8'h4e; 6'h32: c = 8'h4d;
      6'h33: c = 8'h3c; 6'h34: c = 8'h3e; 6'h35: c = 8'h3f; 6'h37: c = 8'h2a;
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Numeric keypad, codes 0x47..0x53
  function automatic logic [7:0] pad_char(input logic [6:0] code);
    logic [7:0] c;
    unique case (code)
      7'h47: c = 8'h37; 7'h48: c = 8'h38; 7'h49: c = 8'h39; 7'h4a: c = 8'h2d;
      7'h4b: c = 8'h34; 7'h4c: c = 8'h35; 7'h4d: c = 8'h36; 7'h4e: c = 8'h2b;
      7'h4f: c = 8'h31; 7'h50: c = 8'h32; 7'h51: c = 8'h33; 7'h52: c = 8'h30;
      7'h53: c = 8'h2c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/keyboard_scancode_translator_core.sv =====
// Top level of the keyboard scan-code translator: beat registers, state and output stage.
`timescale 1ns / 1ps

// Keyboard scan-code translator, German QWERTZ layout.
// in_*  : input events; in_tuser carries the event type, in_tdata the key code
//         and key value. Only key events (type 1) are handled, others vanish.
// out_* : translated characters, at most one beat per input beat.
// cfg_* : cooked_mode register; 0 passes key events on raw, 1 translates them
//         with modifier and caps tracking. Write it only while the block idles.
// Path: the input register loads at acceptance, and the lookup result moves into
// the output register once the output slot is free or draining.
// Throughput: one event per cycle while out_tready is high; the lookup is a
// single pass of table logic between the input register and the output register.
// Stalls: while out_tready is low the output register holds its beat and the
// input register holds the next event; in_tready falls only when both are full.
// Reset (rst_n low, synchronous): both registers empty, all modifiers released,
// caps cleared, raw mode selected.
module keyboard_scancode_translator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,   // cooked_mode
  // input events
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kst_pkg::IN_TDATA_W-1:0]  in_tdata,      // [9:0] key_code, [11:10] key_value
  input  logic [kst_pkg::TYPE_W-1:0]      in_tuser,      // [4:0] event_type
  // results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kst_pkg::OUT_TDATA_W-1:0] out_tdata,     // [9:0] char_code, [11:10] event_value,
                                                         // [20:12] modifier_bits
  output logic                            out_tuser      // [0] is_cooked
);
  import kst_pkg::*;

  logic              cooked_r;
  logic              s1_v_r, s1_v_nxt;
  logic [TYPE_W-1:0] s1_type_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [VAL_W-1:0]  s1_val_r;
  mod_t              mod_r;
  logic              caps_r;
  logic              out_v_r, out_v_nxt;
  logic [CODE_W-1:0] out_char_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_cooked_r;
  mod_t              out_mod_r;
  logic              in_acc;
  logic              adv;
  xlate_res_t        res;

  // Handshake: the lookup stage advances when the output slot is free or draining
  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooked_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cooked_r <= cfg_wr_data;
    end
  end

  // Input register
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_type_r <= in_tuser;
      s1_code_r <= in_tdata[CODE_W-1:0];
      s1_val_r  <= in_tdata[CODE_W+VAL_W-1:CODE_W];
    end
  end

  // Translation
  kst_xlate u_xlate (
    .event_type  (s1_type_r),
    .key_code    (s1_code_r),
    .key_held    (s1_val_r != '0),
    .cooked_mode (cooked_r),
    .mod_flags   (mod_r),
    .caps_flag   (caps_r),
    .res         (res)
  );

  // Modifier and caps state, updated as each event leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= '0;
      caps_r <= 1'b0;
    end else if (adv) begin
      mod_r  <= res.mod_nxt;
      caps_r <= res.caps_nxt;
    end
  end

  // Output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = res.emit;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char_r   <= res.char_code;
      out_val_r    <= s1_val_r;
      out_cooked_r <= res.is_cooked;
      out_mod_r    <= res.modifier_bits;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_cooked_r;
  assign out_tdata  = {{(OUT_TDATA_W - CODE_W - VAL_W - MOD_W){1'b0}},
                       out_mod_r, out_val_r, out_char_r};

  // A raw key event always yields a beat
  a_raw_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cooked_r && s1_type_r == KEY_EVENT) |=> out_tvalid)
    else $error("raw key event lost");

  // Raw mode leaves the modifier and caps state alone
  a_raw_state: assert property (@(posedge clk) disable iff (!rst_n)
    !cooked_r |=> ($stable(mod_r) && $stable(caps_r)))
    else $error("modifier state changed in raw mode");

  // Raw beats carry no modifier bits
  a_raw_mods: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[CODE_W+VAL_W+MOD_W-1:CODE_W+VAL_W] == '0))
    else $error("modifier bits on raw beat");

endmodule

// ===== rtl/core/kst_xlate.sv =====
// Combinational key translation and modifier/caps next-state for one beat.
`timescale 1ns / 1ps

module kst_xlate (
  input  logic [kst_pkg::TYPE_W-1:0] event_type,
  input  logic [kst_pkg::CODE_W-1:0] key_code,
  input  logic                       key_held,     // key_value non-zero
  input  logic                       cooked_mode,
  input  kst_pkg::mod_t              mod_flags,
  input  logic                       caps_flag,
  output kst_pkg::xlate_res_t        res
);
  import kst_pkg::*;

  mod_t              mask;
  logic              shifted;
  logic              ctrl_alt;
  logic [CODE_W-1:0] ch;

  assign mask     = mod_mask(key_code);
  assign shifted  = mod_flags[MB_SHIFTL] | mod_flags[MB_SHIFTR];
  assign ctrl_alt = mod_flags[MB_CTRLL] | mod_flags[MB_CTRLR] |
                    mod_flags[MB_ALTL]  | mod_flags[MB_ALTR];

  // Character lookup: umlauts under Ctrl/Alt, else delete, nav, F1-F4, keypad divide, keypad, main block
  always_comb begin
    ch = '0;
    if (ctrl_alt) begin
      priority if (shifted && key_code == KEY_A)   ch = 10'h0c4;
      else if (shifted && key_code == KEY_O)       ch = 10'h0d6;
      else if (shifted && key_code == KEY_U)       ch = 10'h0dc;
      else if (!shifted && key_code == KEY_A)      ch = 10'h0e4;
      else if (!shifted && key_code == KEY_O)      ch = 10'h0f6;
      else if (!shifted && key_code == KEY_U)      ch = 10'h0fc;
      else if (!shifted && key_code == KEY_S)      ch = 10'h0df;
      else                                         ch = '0;
    end else begin
      unique case (key_code)
        KEY_DEL:   ch = 10'h07f;
        KEY_HOME:  ch = 10'h124;
        KEY_END:   ch = 10'h123;
        KEY_LEFT:  ch = 10'h125;
        KEY_RIGHT: ch = 10'h127;
        KEY_F1:    ch = 10'h170;
        KEY_F2:    ch = 10'h171;
        KEY_F3:    ch = 10'h172;
        KEY_F4:    ch = 10'h173;
        KEY_KPDIV: ch = 10'h02f;
        default: begin
          priority if (key_code >= PAD_FIRST && key_code <= PAD_LAST) begin
            ch = {2'b00, pad_char(key_code[6:0])};
          end else if (key_code >= MAIN_FIRST && key_code <= MAIN_LAST) begin
            if (shifted || caps_flag) begin
              ch = {2'b00, shift_char(key_code[5:0])};
            end else begin
              ch = {2'b00, base_char(key_code[5:0])};
            end
          end else begin
            ch = '0;
          end
        end
      endcase
    end
  end

  // Beat outcome and state update
  always_comb begin
    res.emit          = 1'b0;
    res.char_code     = key_code;
    res.is_cooked     = 1'b0;
    res.modifier_bits = '0;
    res.mod_nxt       = mod_flags;
    res.caps_nxt      = caps_flag;
    if (event_type == KEY_EVENT) begin
      if (!cooked_mode) begin
        // raw pass-through
        res.emit = 1'b1;
      end else if (mask != '0) begin
        // modifier key: held on press or repeat, shift cancels caps
        res.mod_nxt = key_held ? (mod_flags | mask) : (mod_flags & ~mask);
        if (mask[MB_SHIFTL] || mask[MB_SHIFTR]) begin
          res.caps_nxt = 1'b0;
        end
      end else if (key_code == KEY_CAPS) begin
        res.caps_nxt = 1'b1;
      end else begin
        res.emit          = (ch != '0);
        res.char_code     = ch;
        res.is_cooked     = 1'b1;
        res.modifier_bits = mod_flags;
      end
    end
  end

endmodule
